// ===== rtl/core/ptms_pkg.sv =====
// Shared types, codes and helpers for the packed triangular matrix store.
// Used by the front end, the command queue, the back end and the top level.
package ptms_pkg;

	localparam int MAX_WIDTH   = 64;
	localparam int VALUE_BITS  = 32;
	localparam int STORE_DEPTH = MAX_WIDTH * (MAX_WIDTH - 1) / 2;
	localparam int POS_BITS    = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

	// operation codes on the op field
	localparam logic [2:0] OP_INIT   = 3'd0;
	localparam logic [2:0] OP_WRITE  = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_SWAP   = 3'd3;
	localparam logic [2:0] OP_SHRINK = 3'd4;
	localparam logic [2:0] OP_LOCATE = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIAG  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// configuration register indexes
	localparam logic CFG_INITIAL_WIDTH = 1'b0;
	localparam logic CFG_FILL_VALUE    = 1'b1;

	typedef enum logic [2:0] {
		K_NONE,
		K_INIT,
		K_WRITE,
		K_READ,
		K_SWAP,
		K_LOCATE
	} kind_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_FILL,
		B_WRITE,
		B_READ,
		B_SWAP_CHK,
		B_SWAP_RQ,
		B_SWAP_WP,
		B_SWAP_WQ,
		B_LOCATE,
		B_EMIT
	} bstate_t;

	// addr: entry position for read/write, fill count for init,
	// flat index for locate
	typedef struct packed {
		kind_t                   kind;
		logic [1:0]              status;
		logic [WIDTH_BITS-1:0]   width;
		logic [ADDR_BITS-1:0]    addr;
		logic [POS_BITS-1:0]     row_a;
		logic [POS_BITS-1:0]     row_b;
		logic [ADDR_BITS-1:0]    tri_a;
		logic [ADDR_BITS-1:0]    tri_b;
		logic [VALUE_BITS-1:0]   data;
	} cmd_t;

	// n*(n-1)/2
	function automatic logic [ADDR_BITS-1:0] tri_count(input logic [WIDTH_BITS-1:0] n);
		logic [2*WIDTH_BITS-1:0] prod;
		logic [WIDTH_BITS-1:0]   nm1;
		nm1  = n - WIDTH_BITS'(n != '0);
		prod = n * nm1;
		return prod[ADDR_BITS:1];
	endfunction

endpackage

// ===== rtl/core/packed_triangular_matrix_store.sv =====
// Packed lower-triangle store for a symmetric matrix without diagonal.
// Commands pass from the front end through the queue to the back end, which runs init as a fill
// loop, locate as a row search and row swap as read/read/write/write steps (single-port store).
// Throughput: one command executes at a time and holds the back end until its result can enter
// the output register; a two-deep queue keeps accepting beats meanwhile until it is full.
// Reset clears width to 0, initial_width to 64, the fill value to 0; store undefined.
module packed_triangular_matrix_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      op,
	input  logic [ptms_pkg::POS_BITS-1:0]   first_pos,
	input  logic [ptms_pkg::POS_BITS-1:0]   second_pos,
	input  logic [ptms_pkg::VALUE_BITS-1:0] value,
	input  logic [10:0]                     flat_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ptms_pkg::VALUE_BITS-1:0] read_value,
	output logic [ptms_pkg::POS_BITS-1:0]   row_out,
	output logic [ptms_pkg::POS_BITS-1:0]   col_out,
	output logic [ptms_pkg::WIDTH_BITS-1:0] width_now,
	output logic [1:0]                      status
);
	import ptms_pkg::*;

	logic q_full;
	logic q_push;
	logic q_avail;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t head_cmd;

	ptms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.first_pos  (first_pos),
		.second_pos (second_pos),
		.value      (value),
		.flat_index (flat_index),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (push_cmd)
	);

	ptms_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.avail    (q_avail),
		.pop      (q_pop),
		.head     (head_cmd)
	);

	ptms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_avail  (q_avail),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.row_out    (row_out),
		.col_out    (col_out),
		.width_now  (width_now),
		.status     (status)
	);

endmodule

// ===== rtl/core/ptms_front.sv =====
// Front end: accepts input beats, tracks the matrix width, range-checks and
// turns each beat into a command for the back end. Holds the config registers.
// Depends on ptms_pkg.
module ptms_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [31:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [2:0]                      op,
	input  logic [ptms_pkg::POS_BITS-1:0]   first_pos,
	input  logic [ptms_pkg::POS_BITS-1:0]   second_pos,
	input  logic [ptms_pkg::VALUE_BITS-1:0] value,
	input  logic [10:0]                     flat_index,
	input  logic                            q_full,
	output logic                            q_push,
	output ptms_pkg::cmd_t                  q_cmd
);
	import ptms_pkg::*;

	logic [WIDTH_BITS-1:0] width_q;
	logic [WIDTH_BITS-1:0] width_d;
	logic [6:0]            initial_width_q;
	logic [VALUE_BITS-1:0] fill_value_q;
	logic [WIDTH_BITS-1:0] init_w;
	logic [WIDTH_BITS-1:0] tw_arg;
	logic [ADDR_BITS-1:0]  tri_w;
	logic [ADDR_BITS-1:0]  tri_a;
	logic [ADDR_BITS-1:0]  tri_b;
	logic                  a_out;
	logic                  b_out;
	logic                  accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;
	assign q_push    = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_width_q <= 7'd64;
			fill_value_q    <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_INITIAL_WIDTH)
				initial_width_q <= cfg_data[6:0];
			else
				fill_value_q <= VALUE_BITS'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			width_q <= '0;
		else if (accept)
			width_q <= width_d;
	end

	assign init_w = (initial_width_q > 7'(MAX_WIDTH)) ? WIDTH_BITS'(MAX_WIDTH)
	                                                  : WIDTH_BITS'(initial_width_q);
	assign tw_arg = (op == OP_INIT) ? init_w : width_q;
	assign tri_w  = tri_count(tw_arg);
	assign tri_a  = tri_count({1'b0, first_pos});
	assign tri_b  = tri_count({1'b0, second_pos});
	assign a_out  = {1'b0, first_pos} >= width_q;
	assign b_out  = {1'b0, second_pos} >= width_q;

	always_comb begin
		width_d      = width_q;
		q_cmd        = '0;
		q_cmd.kind   = K_NONE;
		q_cmd.status = ST_OK;
		q_cmd.row_a  = first_pos;
		q_cmd.row_b  = second_pos;
		q_cmd.tri_a  = tri_a;
		q_cmd.tri_b  = tri_b;
		q_cmd.data   = value;
		unique case (op)
			OP_INIT: begin
				width_d    = init_w;
				q_cmd.kind = K_INIT;
				q_cmd.addr = tri_w;
				q_cmd.data = fill_value_q;
			end
			OP_WRITE, OP_READ: begin
				if (a_out || b_out)
					q_cmd.status = ST_RANGE;
				else if (first_pos == second_pos)
					q_cmd.status = ST_DIAG;
				else begin
					q_cmd.kind = (op == OP_WRITE) ? K_WRITE : K_READ;
					// lower triangle: row is the larger coordinate
					if (first_pos > second_pos)
						q_cmd.addr = tri_a + ADDR_BITS'(second_pos);
					else
						q_cmd.addr = tri_b + ADDR_BITS'(first_pos);
				end
			end
			OP_SWAP: begin
				if (a_out || b_out)
					q_cmd.status = ST_RANGE;
				else if (first_pos != second_pos)
					q_cmd.kind = K_SWAP;
			end
			OP_SHRINK: begin
				if (width_q != '0)
					width_d = width_q - 1'b1;
			end
			OP_LOCATE: begin
				if (flat_index >= tri_w)
					q_cmd.status = ST_RANGE;
				else begin
					q_cmd.kind = K_LOCATE;
					q_cmd.addr = flat_index;
				end
			end
			default: ;
		endcase
		q_cmd.width = width_d;
	end

endmodule

// ===== rtl/core/ptms_cmd_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on ptms_pkg for the command type.
module ptms_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptms_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           avail,
	input  logic           pop,
	output ptms_pkg::cmd_t head
);
	import ptms_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign avail = cnt_q != 2'd0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/core/ptms_back.sv =====
// Back end: executes queued commands against the single-port entry store
// (fill, write, read, row swap, locate search) and holds the result register.
// Depends on ptms_pkg.
module ptms_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_avail,
	input  ptms_pkg::cmd_t                  cmd,
	output logic                            cmd_pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ptms_pkg::VALUE_BITS-1:0] read_value,
	output logic [ptms_pkg::POS_BITS-1:0]   row_out,
	output logic [ptms_pkg::POS_BITS-1:0]   col_out,
	output logic [ptms_pkg::WIDTH_BITS-1:0] width_now,
	output logic [1:0]                      status
);
	import ptms_pkg::*;

	logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
	logic [VALUE_BITS-1:0] rdata_q;
	logic [VALUE_BITS-1:0] tmp_q;

	bstate_t state_q, state_d;
	cmd_t    cur_q;

	logic [ADDR_BITS-1:0]  cnt_q, cnt_d;
	logic [WIDTH_BITS-1:0] i_q, i_d;
	logic [ADDR_BITS-1:0]  tri_i_q, tri_i_d;
	logic [WIDTH_BITS-1:0] r_q, r_d;
	logic [ADDR_BITS-1:0]  t_q, t_d;

	logic                  mem_we, mem_re;
	logic [ADDR_BITS-1:0]  mem_addr;
	logic [VALUE_BITS-1:0] mem_wdata;
	logic                  cur_load, tmp_load, emit;
	logic [ADDR_BITS-1:0]  p_addr, q_addr, t_next;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic [POS_BITS-1:0]   row_q, col_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [1:0]            status_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_addr];
	end

	// swap partners in column i of rows a and b
	assign p_addr = (i_q < {1'b0, cur_q.row_a}) ? cur_q.tri_a + ADDR_BITS'(i_q)
	                                            : tri_i_q + ADDR_BITS'(cur_q.row_a);
	assign q_addr = (i_q < {1'b0, cur_q.row_b}) ? cur_q.tri_b + ADDR_BITS'(i_q)
	                                            : tri_i_q + ADDR_BITS'(cur_q.row_b);
	assign t_next = t_q + ADDR_BITS'(r_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (cur_load)
			cur_q <= cmd;
		if (tmp_load)
			tmp_q <= rdata_q;
		cnt_q   <= cnt_d;
		i_q     <= i_d;
		tri_i_q <= tri_i_d;
		r_q     <= r_d;
		t_q     <= t_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd_pop   = 1'b0;
		cur_load  = 1'b0;
		tmp_load  = 1'b0;
		emit      = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = cnt_q;
		mem_wdata = cur_q.data;
		cnt_d     = cnt_q;
		i_d       = i_q;
		tri_i_d   = tri_i_q;
		r_d       = r_q;
		t_d       = t_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_avail) begin
					cmd_pop  = 1'b1;
					cur_load = 1'b1;
					cnt_d    = '0;
					i_d      = '0;
					tri_i_d  = '0;
					r_d      = WIDTH_BITS'(1);
					t_d      = '0;
					unique case (cmd.kind)
						K_INIT:   state_d = B_FILL;
						K_WRITE:  state_d = B_WRITE;
						K_READ:   state_d = B_READ;
						K_SWAP:   state_d = B_SWAP_CHK;
						K_LOCATE: state_d = B_LOCATE;
						default:  state_d = B_EMIT;
					endcase
				end
			end
			B_FILL: begin
				if (cnt_q == cur_q.addr)
					state_d = B_EMIT;
				else begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			B_WRITE: begin
				mem_we   = 1'b1;
				mem_addr = cur_q.addr;
				state_d  = B_EMIT;
			end
			B_READ: begin
				mem_re   = 1'b1;
				mem_addr = cur_q.addr;
				state_d  = B_EMIT;
			end
			B_SWAP_CHK: begin
				if (i_q == cur_q.width)
					state_d = B_EMIT;
				else if (i_q == {1'b0, cur_q.row_a} || i_q == {1'b0, cur_q.row_b}) begin
					// crossing positions stay put
					i_d     = i_q + 1'b1;
					tri_i_d = tri_i_q + ADDR_BITS'(i_q);
				end else begin
					mem_re   = 1'b1;
					mem_addr = p_addr;
					state_d  = B_SWAP_RQ;
				end
			end
			B_SWAP_RQ: begin
				tmp_load = 1'b1;
				mem_re   = 1'b1;
				mem_addr = q_addr;
				state_d  = B_SWAP_WP;
			end
			B_SWAP_WP: begin
				mem_we    = 1'b1;
				mem_addr  = p_addr;
				mem_wdata = rdata_q;
				state_d   = B_SWAP_WQ;
			end
			B_SWAP_WQ: begin
				mem_we    = 1'b1;
				mem_addr  = q_addr;
				mem_wdata = tmp_q;
				i_d       = i_q + 1'b1;
				tri_i_d   = tri_i_q + ADDR_BITS'(i_q);
				state_d   = B_SWAP_CHK;
			end
			B_LOCATE: begin
				// advance row while the next row still starts at or below the index
				if (r_q < cur_q.width && t_next <= cur_q.addr) begin
					t_d = t_next;
					r_d = r_q + 1'b1;
				end else
					state_d = B_EMIT;
			end
			B_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			read_value_q <= (cur_q.kind == K_READ) ? rdata_q : '0;
			row_q        <= (cur_q.kind == K_LOCATE) ? r_q[POS_BITS-1:0] : '0;
			col_q        <= (cur_q.kind == K_LOCATE) ? POS_BITS'(cur_q.addr - t_q) : '0;
			width_q      <= cur_q.width;
			status_q     <= cur_q.status;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign row_out    = row_q;
	assign col_out    = col_q;
	assign width_now  = width_q;
	assign status     = status_q;

endmodule

// ===== verif/tb_packed_triangular_matrix_store.sv =====
// Self-checking testbench for packed_triangular_matrix_store.
// Depends on ptms_pkg for sizes, op codes, status codes and register indexes.
// A predictor mirrors the packed store; results are checked beat by beat in order.
module tb_packed_triangular_matrix_store;
	import ptms_pkg::*;

	localparam logic [2:0] OP_UNUSED6 = 3'd6;
	localparam logic [2:0] OP_UNUSED7 = 3'd7;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 50;

	typedef struct packed {
		logic [VALUE_BITS-1:0] read_value;
		logic [POS_BITS-1:0]   row;
		logic [POS_BITS-1:0]   col;
		logic [WIDTH_BITS-1:0] width;
		logic [1:0]            status;
	} reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_index;
	logic [31:0]           cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [2:0]            op;
	logic [POS_BITS-1:0]   first_pos;
	logic [POS_BITS-1:0]   second_pos;
	logic [VALUE_BITS-1:0] value;
	logic [10:0]           flat_index;
	logic                  out_valid;
	logic                  out_stall;
	logic [VALUE_BITS-1:0] read_value;
	logic [POS_BITS-1:0]   row_out;
	logic [POS_BITS-1:0]   col_out;
	logic [WIDTH_BITS-1:0] width_now;
	logic [1:0]            status;

	// predictor state
	logic [VALUE_BITS-1:0] entry_mirror [STORE_DEPTH];
	int unsigned           mirror_width;
	int unsigned           mirror_init_width;
	logic [VALUE_BITS-1:0] mirror_default;

	reply_t pending_replies [$];
	int     fail_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     hold_requests;
	int     hold_seen;
	int     hold_left;
	int     quiet_cycles;

	packed_triangular_matrix_store dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.first_pos  (first_pos),
		.second_pos (second_pos),
		.value      (value),
		.flat_index (flat_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.row_out    (row_out),
		.col_out    (col_out),
		.width_now  (width_now),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned tri_num(int unsigned n);
		return n * (n - (n > 0 ? 1 : 0)) / 2;
	endfunction

	function automatic int unsigned flat_pos(int unsigned r, int unsigned c);
		int unsigned p;
		p = (r > c) ? tri_num(r) + c : tri_num(c) + r;
		return (p < STORE_DEPTH) ? p : 0;
	endfunction

	// updates the mirrored store and returns the reply the block must give
	function automatic reply_t apply_matrix_op(logic [2:0] opc, int unsigned a, int unsigned b,
			logic [VALUE_BITS-1:0] val, int unsigned idx);
		reply_t                rep;
		int unsigned           w;
		int unsigned           r;
		logic [ADDR_BITS-1:0]  p;
		logic [ADDR_BITS-1:0]  q;
		logic [VALUE_BITS-1:0] t;
		rep = '0;
		case (opc)
			OP_INIT: begin
				w = (mirror_init_width > MAX_WIDTH) ? MAX_WIDTH : mirror_init_width;
				mirror_width = w;
				for (int i = 0; i < tri_num(w); i++)
					entry_mirror[ADDR_BITS'(i)] = mirror_default;
			end
			OP_WRITE, OP_READ: begin
				p = ADDR_BITS'(flat_pos(a, b));
				if (a >= mirror_width || b >= mirror_width)
					rep.status = ST_RANGE;
				else if (a == b)
					rep.status = ST_DIAG;
				else if (opc == OP_WRITE)
					entry_mirror[p] = val;
				else
					rep.read_value = entry_mirror[p];
			end
			OP_SWAP: begin
				if (a >= mirror_width || b >= mirror_width) begin
					rep.status = ST_RANGE;
				end else if (a != b) begin
					// crossing positions (a,b) and (b,a) stay put
					for (int i = 0; i < mirror_width; i++) begin
						if (i != a && i != b) begin
							p = ADDR_BITS'(flat_pos(a, i));
							q = ADDR_BITS'(flat_pos(b, i));
							t = entry_mirror[p];
							entry_mirror[p] = entry_mirror[q];
							entry_mirror[q] = t;
						end
					end
				end
			end
			OP_SHRINK: begin
				if (mirror_width > 0)
					mirror_width--;
			end
			OP_LOCATE: begin
				if (idx >= tri_num(mirror_width)) begin
					rep.status = ST_RANGE;
				end else begin
					r = 1;
					while (r < mirror_width && tri_num(r + 1) <= idx)
						r++;
					rep.row = POS_BITS'(r);
					rep.col = POS_BITS'(idx - tri_num(r));
				end
			end
			default: ;
		endcase
		rep.width = WIDTH_BITS'(mirror_width);
		return rep;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// result checking and receiver stalls
	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: result beat expected none actual value %h row %0d col %0d width %0d status %0d",
					$time, read_value, row_out, col_out, width_now, status);
				fail_count++;
			end else begin
				want = pending_replies.pop_front();
				check_field("read_value", want.read_value, read_value);
				check_field("row_out", want.row, row_out);
				check_field("col_out", want.col, col_out);
				check_field("width_now", want.width, width_now);
				check_field("status", want.status, status);
			end
		end
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog: cycles without any beat on any channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("packed_triangular_matrix_store: mismatch");
				$finish;
			end
		end
	end

	task automatic send_cmd(logic [2:0] opc, logic [POS_BITS-1:0] a, logic [POS_BITS-1:0] b,
			logic [VALUE_BITS-1:0] val, logic [10:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= opc;
		first_pos  <= a;
		second_pos <= b;
		value      <= val;
		flat_index <= idx;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		pending_replies.push_back(apply_matrix_op(opc, a, b, val, idx));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_replies.size() != 0);
	endtask

	task automatic cfg_write(logic idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		if (idx == CFG_INITIAL_WIDTH)
			mirror_init_width = data[6:0];
		else
			mirror_default = VALUE_BITS'(data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] width_word, logic [31:0] fill);
		wait_drained();
		cfg_write(CFG_INITIAL_WIDTH, width_word);
		cfg_write(CFG_FILL_VALUE, fill);
	endtask

	function automatic logic [POS_BITS-1:0] pick_pos();
		if (mirror_width > 0 && $urandom_range(99) < 88)
			return POS_BITS'($urandom_range(mirror_width - 1));
		return POS_BITS'($urandom_range(63));
	endfunction

	task automatic random_cmd();
		int unsigned           pick;
		logic [2:0]            opc;
		logic [POS_BITS-1:0]   a;
		logic [POS_BITS-1:0]   b;
		logic [VALUE_BITS-1:0] val;
		logic [10:0]           idx;
		pick = $urandom_range(99);
		a    = pick_pos();
		b    = pick_pos();
		val  = VALUE_BITS'($urandom);
		if ($urandom_range(9) == 0)
			val = $urandom_range(1) ? '1 : '0;
		idx = 11'($urandom_range(2047));
		if (mirror_width > 1 && $urandom_range(9) < 8)
			idx = 11'($urandom_range(tri_num(mirror_width) - 1));
		if (pick < 30)
			opc = OP_WRITE;
		else if (pick < 62)
			opc = OP_READ;
		else if (pick < 72)
			opc = OP_SWAP;
		else if (pick < 87)
			opc = OP_LOCATE;
		else if (pick < 91)
			opc = OP_SHRINK;
		else if (pick < 96)
			opc = OP_INIT;
		else
			opc = $urandom_range(1) ? OP_UNUSED6 : OP_UNUSED7;
		send_cmd(opc, a, b, val, idx);
	endtask

	// nothing stored yet: every read and locate is out of range
	task automatic test_empty_matrix();
		send_cmd(OP_READ, 0, 0, 0, 0);
		send_cmd(OP_SHRINK, 0, 0, 0, 0);
		send_cmd(OP_LOCATE, 0, 0, 0, 0);
		send_cmd(OP_UNUSED6, 63, 63, '1, 11'h7ff);
		send_cmd(OP_UNUSED7, 0, 0, 0, 0);
	endtask

	// init with register reset values, then corners of the full matrix
	task automatic test_full_width();
		send_cmd(OP_INIT, 0, 0, 0, 0);
		send_cmd(OP_WRITE, 63, 62, 32'hffff_ffff, 0);
		send_cmd(OP_WRITE, 0, 63, 32'h0000_0001, 0);
		send_cmd(OP_READ, 62, 63, 0, 0);
		send_cmd(OP_READ, 63, 0, 0, 0);
		send_cmd(OP_WRITE, 5, 5, 32'h1234_5678, 0);
		send_cmd(OP_READ, 10, 10, 0, 0);
		send_cmd(OP_LOCATE, 0, 0, 0, 2015);
		send_cmd(OP_LOCATE, 0, 0, 0, 0);
		send_cmd(OP_LOCATE, 0, 0, 0, 2047);
		send_cmd(OP_SWAP, 0, 63, 0, 0);
		send_cmd(OP_SWAP, 7, 7, 0, 0);
		send_cmd(OP_READ, 0, 62, 0, 0);
		send_cmd(OP_SHRINK, 0, 0, 0, 0);
		send_cmd(OP_READ, 63, 0, 0, 0);
		send_cmd(OP_READ, 63, 63, 0, 0);
		send_cmd(OP_SWAP, 63, 1, 0, 0);
		send_cmd(OP_LOCATE, 0, 0, 0, 1953);
	endtask

	// width register extremes: empty, saturating
	task automatic test_init_widths();
		set_config(32'd0, 32'h0);
		send_cmd(OP_INIT, 0, 0, 0, 0);
		send_cmd(OP_LOCATE, 0, 0, 0, 0);
		set_config(32'd1, 32'h5a5a_a5a5);
		send_cmd(OP_INIT, 0, 0, 0, 0);
		set_config(32'd127, 32'hffff_ffff);
		send_cmd(OP_INIT, 0, 0, 0, 0);
		send_cmd(OP_LOCATE, 0, 0, 0, 2015);
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_output_holdoff();
		hold_requests++;
		for (int i = 1; i < 17; i++) begin
			if (i % 2)
				send_cmd(OP_WRITE, POS_BITS'(i), POS_BITS'(i - 1), VALUE_BITS'($urandom), 0);
			else
				send_cmd(OP_READ, POS_BITS'(i - 2), POS_BITS'(i - 1), 0, 0);
		end
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++)
			random_cmd();
		wait_drained();
		for (int i = 0; i < 4; i++)
			random_cmd();
	endtask

	task automatic test_random_ops(int total, int s_pct, int r_pct);
		int          sent;
		int          len;
		int unsigned sel;
		logic [31:0] width_word;
		logic [31:0] fill;
		send_idle_pct  = s_pct;
		recv_stall_pct = r_pct;
		sent = 0;
		while (sent < total) begin
			// most phases use small widths; full width is slow to fill and swap
			sel = $urandom_range(99);
			if (sel < 60)
				width_word = $urandom_range(2, 10);
			else if (sel < 85)
				width_word = $urandom_range(11, 32);
			else if (sel < 93)
				width_word = MAX_WIDTH;
			else if ($urandom_range(1))
				width_word = $urandom_range(1);
			else
				width_word = $urandom_range(65, 127);
			width_word[31:7] = 25'($urandom);
			sel = $urandom_range(9);
			fill = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hffff_ffff : $urandom;
			set_config(width_word, fill);
			send_cmd(OP_INIT, 0, 0, 0, 0);
			sent++;
			len = $urandom_range(40, 100);
			for (int k = 0; k < len && sent < total; k++) begin
				random_cmd();
				sent++;
			end
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= CFG_INITIAL_WIDTH;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		op         <= OP_INIT;
		first_pos  <= '0;
		second_pos <= '0;
		value      <= '0;
		flat_index <= '0;
		out_stall  <= 1'b0;
		fail_count        = 0;
		hold_requests     = 0;
		hold_seen         = 0;
		hold_left         = 0;
		quiet_cycles      = 0;
		mirror_width      = 0;
		mirror_init_width = MAX_WIDTH;
		mirror_default    = '0;
		foreach (entry_mirror[i])
			entry_mirror[i] = '0;
		send_idle_pct  = 9;
		recv_stall_pct = 79;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_matrix();
		test_full_width();
		test_output_holdoff();
		test_drain_pause();
		test_init_widths();
		test_random_ops(600, 9, 79);
		test_random_ops(600, 79, 9);
		test_random_ops(550, 0, 0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_replies.size() == 0) begin
			$display("packed_triangular_matrix_store: match");
		end else begin
			$display("packed_triangular_matrix_store: mismatch");
		end
		$finish;
	end

endmodule

// ===== packed_triangular_matrix_store.f =====
rtl/core/ptms_pkg.sv
rtl/core/ptms_front.sv
rtl/core/ptms_cmd_fifo.sv
rtl/core/ptms_back.sv
rtl/core/packed_triangular_matrix_store.sv
verif/tb_packed_triangular_matrix_store.sv
